@@ hdl/bfha_pkg.sv @@
// Shared constants and types for the best-fit heap allocator.
// No dependencies; imported by best_fit_heap_allocator_top.
package bfha_pkg;

  // Header marks kept in word 0 of every block.
  localparam logic [31:0] MARK_FREE  = 32'hDEADBEEF;
  localparam logic [31:0] MARK_ALLOC = 32'hBEEFDEAD;

  // Smallest arena in use, in bytes, and the byte address space limit.
  localparam int unsigned MIN_ARENA = 1024;
  localparam int unsigned ADDR_CAP  = 65536;

  // Word offsets inside a block header.
  localparam logic [1:0] OFS_MARK = 2'd0;
  localparam logic [1:0] OFS_SIZE = 2'd1;
  localparam logic [1:0] OFS_NEXT = 2'd2;
  localparam logic [1:0] OFS_PREV = 2'd3;

  // Allocated header bytes and the smallest remainder worth splitting off.
  localparam logic [17:0] ALLOC_HDR = 18'd8;
  localparam logic [17:0] SPLIT_MIN = 18'd32;

  // Operation codes.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_NO_SPACE     = 3'd1,
    STAT_OUTSIDE      = 3'd2,
    STAT_NOT_ALLOC    = 3'd3
  } bfha_status_e;

endpackage

@@ hdl/best_fit_heap_allocator_top.sv @@
// Best-fit heap allocator: sequencer over an in-band header arena memory.
// Depends on bfha_pkg (marks, header offsets, status codes).
//
// Usage: an item enters on in_valid_i/in_stall_o with kind_i (0 allocate,
// 1 free), request_bytes_i and release_address_i. Exactly one result item
// leaves on out_valid_o/out_stall_i with granted_address_o and status_o.
// The block works on one item at a time; in_stall_o is high from acceptance
// until the result has been placed in the output register.
// An allocate visits every free block (two header reads and a check on the
// single memory read port), then reads the links and writes the new headers.
// A free walks the free blocks below the released address, one per cycle,
// then writes the headers, checks the block below and merges with each free
// neighbor that it adjoins.
// Reset and every write on cfg_we_i start a clearing pass over the arena in
// use, one word per cycle, that also lays down the single free block at
// address 0; no item is taken then, and a write drops any item in progress.
// A result that the receiver stalls stays in the output register; the next
// item may be accepted meanwhile, but its result waits until the register
// has been taken.
module best_fit_heap_allocator_top
  import bfha_pkg::*;
#(
  parameter int unsigned ARENA_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] release_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] granted_address_o,
  output logic [2:0]  status_o
);

  localparam int unsigned CAP_BYTES = (ARENA_BYTES < ADDR_CAP) ? ARENA_BYTES : ADDR_CAP;
  localparam int unsigned NWORDS = CAP_BYTES / 4;
  localparam int AW = $clog2(NWORDS);
  localparam int XW = (AW > 16) ? AW : 16;
  localparam logic [16:0] CAP = 17'(CAP_BYTES);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_START,
    S_AW_SZ, S_AW_NX, S_AW_EV, S_AL_RN, S_AL_RP, S_AL_DEC, S_AL_WR,
    S_F_R1, S_F_R2, S_F_HP, S_F_WK, S_F_WR,
    S_AB_R1, S_AB_R2, S_AB_R3, S_AB_R4, S_AB_R5, S_AB_W0, S_AB_W1, S_AB_W2,
    S_F_CP, S_F_CP1, S_F_CP2, S_FIN
  } state_e;

  state_e       state_q;
  logic [13:0]  clr_idx_q;
  logic [16:0]  used_q;
  logic [15:0]  head_q;
  logic         kind_q;
  logic [15:0]  req_q;
  logic [15:0]  rel_q;
  logic [17:0]  need_q;
  logic [15:0]  cur_q;
  logic [15:0]  best_q;
  logic [16:0]  bsize_q;
  logic         found_q;
  logic [15:0]  nx_q;
  logic [15:0]  pv_q;
  logic [15:0]  f_q;
  logic         split_q;
  logic [2:0]   step_q;
  logic [15:0]  p_q;
  logic [16:0]  s_q;
  logic [15:0]  ab_a_q;
  logic [15:0]  ab_b_q;
  logic [16:0]  ab_asz_q;
  logic [16:0]  ab_bsz_q;
  logic [15:0]  ab_nn_q;
  logic         ab_second_q;
  logic [15:0]  res_addr_q;
  logic [2:0]   res_status_q;
  logic         out_valid_q;
  logic [15:0]  out_addr_q;
  logic [2:0]   out_status_q;

  logic [31:0]  mem_q [NWORDS];
  logic [31:0]  rdata_q;

  logic         mem_we;
  logic [15:0]  mem_wword;
  logic [31:0]  mem_wd;
  logic [15:0]  mem_rword;
  logic [XW-1:0] wa_x;
  logic [XW-1:0] ra_x;

  logic [16:0]  round_size;
  logic [15:0]  n0;
  logic [16:0]  n17;
  logic [17:0]  need_c;
  logic [15:0]  p_c;
  logic [15:0]  rd_addr;
  logic [16:0]  rd_size;
  logic         one_blk;
  logic [16:0]  rem_size;
  logic         out_load;

  function automatic logic [15:0] widx(input logic [15:0] a, input logic [1:0] k);
    return {2'b00, a[15:2]} + {14'd0, k};
  endfunction

  // Arena size in use: smallest power of two from 1024 up to the cap that covers the value, else the cap.
  always_comb begin
    round_size = CAP;
    for (int k = 16; k >= 10; k--) begin
      if ((18'd1 << k) >= {1'b0, cfg_wdata_i} && (18'd1 << k) <= {1'b0, CAP}) begin
        round_size = 17'(18'd1 << k);
      end
    end
  end

  always_comb begin
    n0       = (req_q < 16'd8) ? 16'd8 : req_q;
    n17      = ({1'b0, n0} + 17'd3) & ~17'd3;
    need_c   = {1'b0, n17} + ALLOC_HDR;
    p_c      = rel_q - 16'd8;
    rd_addr  = rdata_q[15:0];
    rd_size  = rdata_q[16:0];
    one_blk  = (nx_q == best_q);
    rem_size = 17'({1'b0, bsize_q} - need_q);
  end

  // The finished result moves into the output register once it is free.
  assign out_load = (state_q == S_FIN) && !cfg_we_i && (!out_valid_q || !out_stall_i);

  // Memory port selection for the current sequencer step.
  always_comb begin
    mem_we    = 1'b0;
    mem_wword = '0;
    mem_wd    = '0;
    mem_rword = '0;
    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wword = {2'b00, clr_idx_q};
        if (clr_idx_q == 14'd0) begin
          mem_wd = MARK_FREE;
        end else if (clr_idx_q == 14'd1) begin
          mem_wd = {15'd0, used_q};
        end
      end
      S_START:  mem_rword = widx(p_c, OFS_MARK);
      S_AW_SZ:  mem_rword = widx(cur_q, OFS_SIZE);
      S_AW_NX:  mem_rword = widx(cur_q, OFS_NEXT);
      S_AL_RN:  mem_rword = widx(best_q, OFS_NEXT);
      S_AL_RP:  mem_rword = widx(best_q, OFS_PREV);
      S_AL_WR: begin
        mem_we = 1'b1;
        if (!split_q) begin
          case (step_q)
            3'd0: begin mem_wword = widx(pv_q, OFS_NEXT); mem_wd = {16'd0, nx_q}; end
            3'd1: begin mem_wword = widx(nx_q, OFS_PREV); mem_wd = {16'd0, pv_q}; end
            default: begin mem_wword = widx(best_q, OFS_MARK); mem_wd = MARK_ALLOC; end
          endcase
        end else begin
          case (step_q)
            3'd0: begin mem_wword = widx(f_q, OFS_MARK); mem_wd = MARK_FREE; end
            3'd1: begin mem_wword = widx(f_q, OFS_SIZE); mem_wd = {15'd0, rem_size}; end
            3'd2: begin
              mem_wword = widx(f_q, OFS_NEXT);
              mem_wd    = {16'd0, one_blk ? f_q : nx_q};
            end
            3'd3: begin
              mem_wword = widx(f_q, OFS_PREV);
              mem_wd    = {16'd0, one_blk ? f_q : pv_q};
            end
            3'd4: begin mem_wword = widx(nx_q, OFS_PREV); mem_wd = {16'd0, f_q}; end
            3'd5: begin mem_wword = widx(pv_q, OFS_NEXT); mem_wd = {16'd0, f_q}; end
            3'd6: begin mem_wword = widx(best_q, OFS_MARK); mem_wd = MARK_ALLOC; end
            default: begin mem_wword = widx(best_q, OFS_SIZE); mem_wd = {14'd0, need_q}; end
          endcase
        end
      end
      S_F_R1:   mem_rword = widx(p_q, OFS_SIZE);
      S_F_R2:   mem_rword = (p_q < head_q) ? widx(head_q, OFS_PREV) : widx(head_q, OFS_NEXT);
      S_F_WK:   mem_rword = widx(rd_addr, OFS_NEXT);
      S_F_WR: begin
        mem_we = 1'b1;
        case (step_q)
          3'd0: begin mem_wword = widx(p_q, OFS_MARK); mem_wd = MARK_FREE; end
          3'd1: begin mem_wword = widx(p_q, OFS_SIZE); mem_wd = {15'd0, s_q}; end
          3'd2: begin mem_wword = widx(p_q, OFS_NEXT); mem_wd = {16'd0, nx_q}; end
          3'd3: begin mem_wword = widx(p_q, OFS_PREV); mem_wd = {16'd0, pv_q}; end
          3'd4: begin mem_wword = widx(pv_q, OFS_NEXT); mem_wd = {16'd0, p_q}; end
          default: begin mem_wword = widx(nx_q, OFS_PREV); mem_wd = {16'd0, p_q}; end
        endcase
      end
      S_AB_R1:  mem_rword = widx(ab_a_q, OFS_SIZE);
      S_AB_R2:  mem_rword = widx(ab_a_q, OFS_NEXT);
      S_AB_R3:  mem_rword = widx(rd_addr, OFS_SIZE);
      S_AB_R4:  mem_rword = widx(ab_b_q, OFS_NEXT);
      S_AB_W0: begin
        mem_we    = 1'b1;
        mem_wword = widx(ab_a_q, OFS_SIZE);
        mem_wd    = {15'd0, 17'(ab_asz_q + ab_bsz_q)};
      end
      S_AB_W1: begin
        mem_we    = 1'b1;
        mem_wword = widx(ab_a_q, OFS_NEXT);
        mem_wd    = {16'd0, (ab_nn_q == ab_a_q) ? ab_a_q : ab_nn_q};
      end
      S_AB_W2: begin
        mem_we    = 1'b1;
        mem_wword = (ab_nn_q == ab_a_q) ? widx(ab_a_q, OFS_PREV) : widx(ab_nn_q, OFS_PREV);
        mem_wd    = {16'd0, ab_a_q};
      end
      S_F_CP:   mem_rword = widx(p_q, OFS_PREV);
      S_F_CP1:  mem_rword = widx(rd_addr, OFS_SIZE);
      default: ;
    endcase
  end

  // Word addresses wrap at the memory depth.
  assign wa_x = XW'(mem_wword);
  assign ra_x = XW'(mem_rword);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wa_x[AW-1:0]] <= mem_wd;
    end
    rdata_q <= mem_q[ra_x[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_idx_q   <= '0;
      used_q      <= CAP;
      head_q      <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        state_q   <= S_CLR;
        clr_idx_q <= '0;
        used_q    <= round_size;
        head_q    <= '0;
      end else begin
        unique case (state_q)
          S_CLR: begin
            clr_idx_q <= clr_idx_q + 14'd1;
            if ({1'b0, clr_idx_q} == used_q[16:2] - 15'd1) begin
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid_i) begin
              kind_q  <= kind_i;
              req_q   <= request_bytes_i;
              rel_q   <= release_address_i;
              state_q <= S_START;
            end
          end
          S_START: begin
            if (kind_q == KIND_ALLOC) begin
              need_q  <= need_c;
              cur_q   <= head_q;
              found_q <= 1'b0;
              state_q <= S_AW_SZ;
            end else if (rel_q < 16'd8 || {1'b0, rel_q} > used_q) begin
              res_addr_q   <= '0;
              res_status_q <= STAT_OUTSIDE;
              state_q      <= S_FIN;
            end else if (rel_q[1:0] != 2'b00) begin
              res_addr_q   <= '0;
              res_status_q <= STAT_NOT_ALLOC;
              state_q      <= S_FIN;
            end else begin
              p_q     <= p_c;
              state_q <= S_F_R1;
            end
          end
          S_AW_SZ: state_q <= S_AW_NX;
          S_AW_NX: begin
            if ({1'b0, rd_size} >= need_q && (!found_q || rd_size < bsize_q)) begin
              best_q  <= cur_q;
              bsize_q <= rd_size;
              found_q <= 1'b1;
            end
            state_q <= S_AW_EV;
          end
          S_AW_EV: begin
            if (rd_addr == head_q) begin
              if (found_q) begin
                state_q <= S_AL_RN;
              end else begin
                res_addr_q   <= '0;
                res_status_q <= STAT_NO_SPACE;
                state_q      <= S_FIN;
              end
            end else begin
              cur_q   <= rd_addr;
              state_q <= S_AW_SZ;
            end
          end
          S_AL_RN: state_q <= S_AL_RP;
          S_AL_RP: begin
            nx_q    <= rd_addr;
            state_q <= S_AL_DEC;
          end
          S_AL_DEC: begin
            pv_q   <= rd_addr;
            step_q <= '0;
            if ({1'b0, bsize_q} < need_q + SPLIT_MIN) begin
              if (one_blk) begin
                // The only free block is never handed out whole.
                res_addr_q   <= '0;
                res_status_q <= STAT_NO_SPACE;
                state_q      <= S_FIN;
              end else begin
                split_q <= 1'b0;
                if (head_q == best_q) begin
                  head_q <= nx_q;
                end
                state_q <= S_AL_WR;
              end
            end else begin
              split_q <= 1'b1;
              f_q     <= best_q + need_q[15:0];
              if (head_q == best_q) begin
                head_q <= best_q + need_q[15:0];
              end
              state_q <= S_AL_WR;
            end
          end
          S_AL_WR: begin
            step_q <= step_q + 3'd1;
            if ((!split_q && step_q == 3'd2) || (split_q && step_q == 3'd7)) begin
              res_addr_q   <= best_q + 16'd8;
              res_status_q <= STAT_OK;
              state_q      <= S_FIN;
            end
          end
          S_F_R1: begin
            if (rdata_q != MARK_ALLOC) begin
              res_addr_q   <= '0;
              res_status_q <= STAT_NOT_ALLOC;
              state_q      <= S_FIN;
            end else begin
              state_q <= S_F_R2;
            end
          end
          S_F_R2: begin
            s_q    <= rd_size;
            step_q <= '0;
            if (p_q < head_q) begin
              state_q <= S_F_HP;
            end else begin
              cur_q   <= head_q;
              state_q <= S_F_WK;
            end
          end
          S_F_HP: begin
            pv_q    <= rd_addr;
            nx_q    <= head_q;
            state_q <= S_F_WR;
          end
          S_F_WK: begin
            // Stop at the wrap back to the head or at the first block above p.
            if (rd_addr == head_q || rd_addr > p_q) begin
              pv_q    <= cur_q;
              nx_q    <= rd_addr;
              state_q <= S_F_WR;
            end else begin
              cur_q <= rd_addr;
            end
          end
          S_F_WR: begin
            step_q <= step_q + 3'd1;
            if (step_q == 3'd5) begin
              if (p_q < head_q) begin
                head_q <= p_q;
              end
              if ({2'b00, p_q} + {1'b0, s_q} == {2'b00, nx_q}) begin
                ab_a_q      <= p_q;
                ab_second_q <= 1'b0;
                state_q     <= S_AB_R1;
              end else begin
                state_q <= S_F_CP;
              end
            end
          end
          S_AB_R1: state_q <= S_AB_R2;
          S_AB_R2: begin
            ab_asz_q <= rd_size;
            state_q  <= S_AB_R3;
          end
          S_AB_R3: begin
            ab_b_q  <= rd_addr;
            state_q <= S_AB_R4;
          end
          S_AB_R4: begin
            ab_bsz_q <= rd_size;
            state_q  <= S_AB_R5;
          end
          S_AB_R5: begin
            ab_nn_q <= rd_addr;
            state_q <= S_AB_W0;
          end
          S_AB_W0: state_q <= S_AB_W1;
          S_AB_W1: state_q <= S_AB_W2;
          S_AB_W2: begin
            if (ab_second_q) begin
              res_addr_q   <= '0;
              res_status_q <= STAT_OK;
              state_q      <= S_FIN;
            end else begin
              state_q <= S_F_CP;
            end
          end
          S_F_CP: state_q <= S_F_CP1;
          S_F_CP1: begin
            ab_a_q  <= rd_addr;
            state_q <= S_F_CP2;
          end
          S_F_CP2: begin
            // Merge into the previous block when it ends exactly at p.
            if (ab_a_q != p_q &&
                {2'b00, ab_a_q} + {1'b0, rd_size} == {2'b00, p_q}) begin
              ab_second_q <= 1'b1;
              state_q     <= S_AB_R1;
            end else begin
              res_addr_q   <= '0;
              res_status_q <= STAT_OK;
              state_q      <= S_FIN;
            end
          end
          S_FIN: begin
            if (out_load) begin
              out_addr_q   <= res_addr_q;
              out_status_q <= res_status_q;
              state_q      <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;

endmodule
